>>> rtl/daq_listfile_word_parser_assert.svh
// assertion macros shared by the list stream word parser modules
`ifndef DAQ_LISTFILE_WORD_PARSER_ASSERT_SVH
`define DAQ_LISTFILE_WORD_PARSER_ASSERT_SVH

// same-cycle implication, clocked on clock, off during reset
`define DLWP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("dlwp assertion failed");

// next-cycle implication, clocked on clock, off during reset
`define DLWP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("dlwp assertion failed");

`endif

>>> rtl/dlwp_pkg.sv
// types, codes and constants of the list stream word parser
package dlwp_pkg;

   localparam int WORD_W    = 32;
   localparam int COUNT_W   = 20;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic [WORD_W-1:0] FILL_WORD = 32'hffff_ffff;

   // section types from header bits 31..29
   localparam logic [2:0] SEC_EVENT = 3'd1;
   localparam logic [2:0] SEC_END   = 3'd2;

   // data word signatures from bits 31..28, the event time signature from bits 31..30
   localparam logic [3:0] SIG_ADC      = 4'd1;
   localparam logic [3:0] SIG_EXT_TIME = 4'd2;
   localparam logic [1:0] SIG_EVT_TIME = 2'b11;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FORMAT   = 2'd0,
      CSR_MODULE_A = 2'd1,
      CSR_MODULE_B = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ITEM_NONE     = 3'd0,
      ITEM_ADC_HIT  = 3'd1,
      ITEM_EXT_TIME = 3'd2,
      ITEM_EVT_TIME = 3'd3,
      ITEM_CLOSED   = 3'd4,
      ITEM_END      = 3'd5,
      ITEM_ERROR    = 3'd6
   } item_kind_type;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_SKIP    = 3'd1,
      PH_SUBHDR  = 3'd2,
      PH_SUBDATA = 3'd3,
      PH_MARKER  = 3'd4,
      PH_DONE    = 3'd5
   } phase_type;

   typedef struct packed {
      logic       format_version;
      logic [7:0] module_a;
      logic [7:0] module_b;
   } cfg_type;

   typedef struct packed {
      item_kind_type item_kind;
      logic [4:0]    channel;
      logic [15:0]   adc_value;
      logic          pileup_flag;
      logic          overflow_flag;
      logic [15:0]   extended_time;
      logic [29:0]   event_time;
      logic [3:0]    event_kind;
      logic [7:0]    module_kind;
      logic [31:0]   event_number;
      logic [31:0]   marker_word;
   } result_type;

endpackage

>>> rtl/dlwp_if.sv
// channel interfaces: stream words in, result words out, register writes

interface dlwp_word_if import dlwp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] stream_word;

   modport source (output valid, output stream_word, input ready);
   modport sink   (input valid, input stream_word, output ready);
endinterface

interface dlwp_rsp_if import dlwp_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [2:0]  item_kind;
   logic [4:0]  channel;
   logic [15:0] adc_value;
   logic        pileup_flag;
   logic        overflow_flag;
   logic [15:0] extended_time;
   logic [29:0] event_time;
   logic [3:0]  event_kind;
   logic [7:0]  module_kind;
   logic [31:0] event_number;
   logic [31:0] marker_word;

   modport source (output valid, output item_kind, output channel, output adc_value,
                   output pileup_flag, output overflow_flag, output extended_time,
                   output event_time, output event_kind, output module_kind,
                   output event_number, output marker_word, input ready);
   modport sink   (input valid, input item_kind, input channel, input adc_value,
                   input pileup_flag, input overflow_flag, input extended_time,
                   input event_time, input event_kind, input module_kind,
                   input event_number, input marker_word, output ready);
endinterface

interface dlwp_csr_if import dlwp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/daq_listfile_word_parser.sv
// list stream word parser top level: input register, decode, result register
// an accepted word waits in the input register until the result register is free, then its decode is registered there
// throughput: one word per cycle while results are taken, set by the single decode pass between the registers
// while a result waits, one more word is taken into the input register, then the input stalls
// synchronous active-high reset empties both registers, returns framing to the
// section header phase and loads the configuration defaults
`include "daq_listfile_word_parser_assert.svh"

module daq_listfile_word_parser import dlwp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dlwp_word_if.sink  req_if,
   dlwp_rsp_if.source rsp_if,
   dlwp_csr_if.sink   csr_if
);

   cfg_type           cfg;
   result_type        result;
   logic              word_valid_ff, word_valid_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff, rsp_data_in;
   logic              advance;
   logic              req_take;

   dlwp_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   dlwp_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .word   (word_ff),
      .cfg    (cfg),
      .result (result)
   );

   // handshake between the two registers
   assign advance      = word_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !word_valid_ff || advance;
   assign req_take     = req_if.valid && req_if.ready;

   // input word register
   always_comb begin
      word_valid_in = word_valid_ff;
      word_in       = word_ff;
      if (req_take) begin
         word_valid_in = 1'b1;
         word_in       = req_if.stream_word;
      end else if (advance) begin
         word_valid_in = 1'b0;
      end
   end

   // result word register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   // result channel
   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.item_kind     = rsp_data_ff.item_kind;
   assign rsp_if.channel       = rsp_data_ff.channel;
   assign rsp_if.adc_value     = rsp_data_ff.adc_value;
   assign rsp_if.pileup_flag   = rsp_data_ff.pileup_flag;
   assign rsp_if.overflow_flag = rsp_data_ff.overflow_flag;
   assign rsp_if.extended_time = rsp_data_ff.extended_time;
   assign rsp_if.event_time    = rsp_data_ff.event_time;
   assign rsp_if.event_kind    = rsp_data_ff.event_kind;
   assign rsp_if.module_kind   = rsp_data_ff.module_kind;
   assign rsp_if.event_number  = rsp_data_ff.event_number;
   assign rsp_if.marker_word   = rsp_data_ff.marker_word;

   // a held word with a blocked result stage closes the input
   `DLWP_ASSERT_SAME(a_stall_blocks_req, word_valid_ff && rsp_valid_ff && !rsp_if.ready, !req_if.ready)
   // a decoded word always lands in the result register
   `DLWP_ASSERT_NEXT(a_advance_fills_rsp, advance, rsp_valid_ff)

endmodule

>>> rtl/dlwp_csr.sv
// configuration registers of the list stream word parser
module dlwp_csr import dlwp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   dlwp_csr_if.sink   csr_if,
   output cfg_type    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_FORMAT:   cfg_in.format_version = csr_if.data[0];
            CSR_MODULE_A: cfg_in.module_a       = csr_if.data;
            CSR_MODULE_B: cfg_in.module_b       = csr_if.data;
            default:      cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_version <= 1'b1;
         cfg_ff.module_a       <= 8'd4;
         cfg_ff.module_b       <= 8'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/dlwp_decode.sv
// framing state machine and word decode of the list stream parser
`include "daq_listfile_word_parser_assert.svh"

module dlwp_decode import dlwp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [WORD_W-1:0] word,
   input  cfg_type           cfg,
   output result_type        result
);

   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] sec_left_ff, sec_left_in;
   logic [COUNT_W-1:0] sub_left_ff, sub_left_in;
   logic [7:0]         module_ff, module_in;
   logic [3:0]         evt_kind_ff, evt_kind_in;
   logic [31:0]        events_ff, events_in;

   logic [2:0]         hdr_type;
   logic [COUNT_W-1:0] hdr_size;
   logic [3:0]         hdr_evt_kind;
   logic [7:0]         sub_module;
   logic [COUNT_W-1:0] sub_size_raw;
   logic [COUNT_W-1:0] sec_dec;
   logic [COUNT_W-1:0] sub_dec;
   logic               sub_overrun;
   logic [COUNT_W-1:0] sub_size;
   logic               decoded;
   phase_type          after_sub;

   // header and subevent header fields by layout version
   assign hdr_type     = word[31:29];
   assign hdr_size     = cfg.format_version ? word[19:0] : {4'd0, word[15:0]};
   assign hdr_evt_kind = cfg.format_version ? word[28:25] : word[19:16];
   assign sub_module   = cfg.format_version ? word[31:24] : {2'd0, word[17:12]};
   assign sub_size_raw = cfg.format_version ? word[19:0] : {10'd0, word[9:0]};

   // word counters
   assign sec_dec = sec_left_ff - COUNT_W'(1);
   assign sub_dec = sub_left_ff - COUNT_W'(1);

   // subevent that does not fit in front of the end marker gets clipped
   assign sub_overrun = (sec_dec == '0) || (sub_size_raw > sec_dec - COUNT_W'(1));
   assign sub_size    = !sub_overrun    ? sub_size_raw :
                        (sec_dec != '0) ? sec_dec - COUNT_W'(1) : '0;
   assign after_sub   = (sec_dec > COUNT_W'(1)) ? PH_SUBHDR : PH_MARKER;

   assign decoded = (word != FILL_WORD) &&
                    ((module_ff == cfg.module_a) || (module_ff == cfg.module_b));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_type == SEC_EVENT) begin
               phase_in = (hdr_size > COUNT_W'(1)) ? PH_SUBHDR : PH_MARKER;
            end else if (hdr_type == SEC_END) begin
               phase_in = PH_DONE;
            end else begin
               phase_in = (hdr_size != '0) ? PH_SKIP : PH_HEADER;
            end
         end
         PH_SKIP: begin
            if (sec_dec == '0) phase_in = PH_HEADER;
         end
         PH_SUBHDR: begin
            phase_in = (sub_size != '0) ? PH_SUBDATA : after_sub;
         end
         PH_SUBDATA: begin
            if (sub_dec == '0) phase_in = after_sub;
         end
         PH_MARKER: phase_in = PH_HEADER;
         default:   phase_in = PH_DONE;
      endcase
   end

   // counters, context and result word
   always_comb begin
      sec_left_in = sec_left_ff;
      sub_left_in = sub_left_ff;
      module_in   = module_ff;
      evt_kind_in = evt_kind_ff;
      events_in   = events_ff;
      result      = '0;
      unique case (phase_ff)
         PH_HEADER: begin
            if (hdr_type == SEC_EVENT) begin
               evt_kind_in = hdr_evt_kind;
               sec_left_in = hdr_size;
            end else if (hdr_type == SEC_END) begin
               result.item_kind    = ITEM_END;
               result.event_number = events_ff;
            end else begin
               sec_left_in = hdr_size;
            end
         end
         PH_SKIP: sec_left_in = sec_dec;
         PH_SUBHDR: begin
            sec_left_in = sec_dec;
            module_in   = sub_module;
            sub_left_in = sub_size;
            if (sub_overrun) begin
               result.item_kind    = ITEM_ERROR;
               result.module_kind  = sub_module;
               result.event_number = events_ff;
            end
         end
         PH_SUBDATA: begin
            sec_left_in = sec_dec;
            sub_left_in = sub_dec;
            if (decoded) begin
               if (word[31:28] == SIG_ADC) begin
                  result.item_kind     = ITEM_ADC_HIT;
                  result.channel       = word[20:16];
                  result.adc_value     = word[15:0];
                  result.pileup_flag   = word[23];
                  result.overflow_flag = word[22];
               end else if (word[31:28] == SIG_EXT_TIME) begin
                  result.item_kind     = ITEM_EXT_TIME;
                  result.extended_time = word[15:0];
               end else if (word[31:30] == SIG_EVT_TIME) begin
                  result.item_kind  = ITEM_EVT_TIME;
                  result.event_time = word[29:0];
               end
               if (result.item_kind != ITEM_NONE) begin
                  result.event_kind   = evt_kind_ff;
                  result.module_kind  = module_ff;
                  result.event_number = events_ff;
               end
            end
         end
         PH_MARKER: begin
            result.item_kind    = ITEM_CLOSED;
            result.event_kind   = evt_kind_ff;
            result.event_number = events_ff;
            result.marker_word  = word;
            events_in           = events_ff + 32'd1;
            sec_left_in         = '0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         sec_left_ff <= '0;
         sub_left_ff <= '0;
         module_ff   <= '0;
         evt_kind_ff <= '0;
         events_ff   <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         sec_left_ff <= sec_left_in;
         sub_left_ff <= sub_left_in;
         module_ff   <= module_in;
         evt_kind_ff <= evt_kind_in;
         events_ff   <= events_in;
      end
   end

   // event counter moves exactly with a close
   `DLWP_ASSERT_NEXT(a_close_counts, step && (result.item_kind == ITEM_CLOSED), events_ff == $past(events_ff) + 32'd1)
   // end of stream is final until reset
   `DLWP_ASSERT_NEXT(a_done_sticks, phase_ff == PH_DONE, phase_ff == PH_DONE)
   // a subevent in progress always has words left
   `DLWP_ASSERT_SAME(a_subdata_left, phase_ff == PH_SUBDATA, sub_left_ff != '0)

endmodule
